FILE: rtl/modular_multiply_shift_add_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the modular multiply core checker
// All checks sample on clk and are disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MODULAR_MULTIPLY_SHIFT_ADD_CORE_MACROS_SVH
`define MODULAR_MULTIPLY_SHIFT_ADD_CORE_MACROS_SVH

// Clocked property with reset disable
`define MMSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent in this cycle, consequent in the next cycle
`define MMSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	`MMSA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/mmsa_pkg.sv
// ----------------------------------------------------------------------------
// mmsa_pkg
// Shared types and constants for the shift-add modular multiply core.
// ----------------------------------------------------------------------------
package mmsa_pkg;

	// Fixed width of the multiplicand, multiplier, modulus and product fields
	localparam int FIELD_W = 63;

	// Default operand width used by the core
	localparam int OPERAND_WIDTH_DEF = 63;

	// Request payload
	typedef struct packed {
		logic [FIELD_W-1:0] multiplicand;
		logic [FIELD_W-1:0] multiplier;
		logic [FIELD_W-1:0] modulus;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [FIELD_W-1:0] product_mod;
		logic               zero_modulus;
	} rsp_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic reduce_step;
		logic mult_step;
		logic out_load;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic mod_zero;
	} sts_t;

endpackage

FILE: rtl/mmsa_ctrl.sv
// ----------------------------------------------------------------------------
// mmsa_ctrl
// Sequencer: accepts a request, runs the reduction and multiply passes,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module mmsa_ctrl #(
	parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output mmsa_pkg::cmd_t cmd,
	input  mmsa_pkg::sts_t sts
);
	import mmsa_pkg::*;

	localparam int CW = $clog2(OPERAND_WIDTH);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_REDUCE = 3'd2;
	localparam logic [2:0] ST_MULT   = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0]    state_q;
	logic [2:0]    state_nxt;
	logic [CW-1:0] cnt_q;
	logic          last_step;
	logic          rsp_valid_q;

	assign last_step = (cnt_q == CW'(OPERAND_WIDTH - 1));
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_nxt = sts.mod_zero ? ST_DONE : ST_REDUCE;
			end
			ST_REDUCE: begin
				cmd.reduce_step = 1'b1;
				if (last_step) begin
					state_nxt = ST_MULT;
				end
			end
			ST_MULT: begin
				cmd.mult_step = 1'b1;
				if (last_step) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				// wait for room in the output register
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State, bit counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == ST_REDUCE || state_q == ST_MULT) && !last_step) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/mmsa_dp.sv
// ----------------------------------------------------------------------------
// mmsa_dp
// Datapath: restoring reduction of the multiplicand, then one multiplier
// bit per step of conditional add and doubling, both kept below the modulus.
// ----------------------------------------------------------------------------
module mmsa_dp #(
	parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic           clk,
	input  mmsa_pkg::req_t  req_data,
	input  mmsa_pkg::cmd_t  cmd,
	output mmsa_pkg::sts_t  sts,
	output mmsa_pkg::rsp_t  rsp_data
);
	import mmsa_pkg::*;

	localparam int W = OPERAND_WIDTH;

	logic [W-1:0]       mod_q;
	logic [W-1:0]       mcand_q;
	logic [W-1:0]       mplier_q;
	logic [W-1:0]       addend_q;
	logic [W-1:0]       acc_q;
	logic [FIELD_W-1:0] product_q;
	logic               zflag_q;

	logic [W:0]   rem_shift;
	logic [W:0]   rem_diff;
	logic [W-1:0] rem_next;
	logic [W:0]   acc_sum;
	logic [W:0]   acc_diff;
	logic [W-1:0] acc_next;
	logic [W:0]   dbl_sum;
	logic [W:0]   dbl_diff;
	logic [W-1:0] dbl_next;

	assign sts.mod_zero = (mod_q == '0);

	// Restoring remainder step: bring in next multiplicand bit, subtract if fits
	always_comb begin
		rem_shift = {addend_q, mcand_q[W-1]};
		rem_diff  = rem_shift - {1'b0, mod_q};
		rem_next  = rem_diff[W] ? rem_shift[W-1:0] : rem_diff[W-1:0];
	end

	// Accumulate step: acc + addend, reduced once
	always_comb begin
		acc_sum  = {1'b0, acc_q} + {1'b0, addend_q};
		acc_diff = acc_sum - {1'b0, mod_q};
		acc_next = acc_diff[W] ? acc_sum[W-1:0] : acc_diff[W-1:0];
	end

	// Doubling step: 2 * addend, reduced once
	always_comb begin
		dbl_sum  = {addend_q, 1'b0};
		dbl_diff = dbl_sum - {1'b0, mod_q};
		dbl_next = dbl_diff[W] ? dbl_sum[W-1:0] : dbl_diff[W-1:0];
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mod_q    <= req_data.modulus[W-1:0];
			mcand_q  <= req_data.multiplicand[W-1:0];
			mplier_q <= req_data.multiplier[W-1:0];
			addend_q <= '0;
			acc_q    <= '0;
		end else if (cmd.reduce_step) begin
			addend_q <= rem_next;
			mcand_q  <= mcand_q << 1;
		end else if (cmd.mult_step) begin
			if (mplier_q[0]) begin
				acc_q <= acc_next;
			end
			addend_q <= dbl_next;
			mplier_q <= mplier_q >> 1;
		end
	end

	// Output register; acc stays zero when the modulus is zero
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			product_q <= FIELD_W'(acc_q);
			zflag_q   <= sts.mod_zero;
		end
	end

	assign rsp_data.product_mod  = product_q;
	assign rsp_data.zero_modulus = zflag_q;

endmodule

FILE: rtl/modular_multiply_shift_add_core.sv
// ----------------------------------------------------------------------------
// modular_multiply_shift_add_core
// Computes (multiplicand * multiplier) mod modulus by shift and add.
// ----------------------------------------------------------------------------
// One request at a time. A request with a nonzero modulus is loaded by
// the idle state that takes it and its modulus is tested in the check
// state; then come OPERAND_WIDTH steps of one-bit restoring reduction of
// the multiplicand, OPERAND_WIDTH steps of conditional add and doubling,
// one per multiplier bit, and the done state, which writes the output
// register once it has room. A zero modulus skips both passes and returns
// a zero product with zero_modulus set. Only the low OPERAND_WIDTH bits of
// each field are used. The output register lets a new request start while
// the previous response waits to be taken.
// ----------------------------------------------------------------------------
module modular_multiply_shift_add_core #(
	parameter int OPERAND_WIDTH = mmsa_pkg::OPERAND_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  mmsa_pkg::req_t  req_data,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output mmsa_pkg::rsp_t  rsp_data
);
	import mmsa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// Sequencer
	mmsa_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Arithmetic
	mmsa_dp #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dp (
		.clk     (clk),
		.req_data(req_data),
		.cmd     (cmd),
		.sts     (sts),
		.rsp_data(rsp_data)
	);

endmodule

FILE: rtl/mmsa_checker.sv
// ----------------------------------------------------------------------------
// mmsa_checker
// Port-level checks for the modular multiply core, bound to the top level.
// ----------------------------------------------------------------------------
`include "modular_multiply_shift_add_core_macros.svh"

module mmsa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input mmsa_pkg::req_t  req_data,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input mmsa_pkg::rsp_t  rsp_data
);
	import mmsa_pkg::*;

	// A stalled response holds its value
	`MMSA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response changed while stalled")

	// Only one request in work: the core is busy right after a request
	`MMSA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready, "request taken while busy")

	// A zero-modulus response carries a zero product
	`MMSA_ASSERT(a_zero_mod_result, rsp_valid && rsp_data.zero_modulus |-> rsp_data.product_mod == '0, "nonzero product on zero modulus")

	// A zero-modulus request taken while no response waits is answered once the check and done states have passed
	`MMSA_ASSERT(a_zero_mod_fast, req_valid && req_ready && req_data.modulus == '0 && !rsp_valid |-> ##3 rsp_valid && rsp_data.zero_modulus, "zero modulus not flagged")

endmodule

bind modular_multiply_shift_add_core mmsa_checker u_mmsa_checker (.*);
